### rtl/text_console_cursor_controller_assert.svh
// Assertion helpers shared by the console controller.
`ifndef TEXT_CONSOLE_CURSOR_CONTROLLER_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCCC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tccc_pkg.sv
package tccc_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS = 1'b1;

   // control bytes
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_BEL = 8'h07;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_FF  = 8'h0C;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_LBR = 8'h5B;
   localparam logic [7:0] CH_C   = 8'h43;

   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_PRINTED   = 3'd1,
      ACT_NEWLINE   = 3'd2,
      ACT_BACKSPACE = 3'd3,
      ACT_RETURN    = 3'd4,
      ACT_FORMFEED  = 3'd5,
      ACT_RIGHT     = 3'd6,
      ACT_ERROR     = 3'd7
   } action_type;

   // escape sequence progress
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ESC  = 2'd1,
      PH_CSI  = 2'd2
   } phase_type;

   // one cell RAM word
   typedef struct packed {
      logic       valid;
      logic [7:0] ch;
   } cell_type;

   localparam int CELL_W = $bits(cell_type);

   // clear requests to the sweep engine
   typedef struct packed {
      logic row;
      logic all;
   } clr_req_type;

   // one result beat
   typedef struct packed {
      action_type action;
      logic [7:0] printed_char;
      logic [5:0] printed_col;
      logic [4:0] printed_row;
      logic       scrolled;
      logic [5:0] new_cursor_col;
      logic [4:0] new_cursor_row;
      logic [7:0] char_under_cursor;
      logic [4:0] ring_first_row;
      logic [4:0] view_row_offset;
      logic       last_of_run;
   } rsp_type;

endpackage

### rtl/tccc_ram.sv
module tccc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

### rtl/tccc_sweep.sv
module tccc_sweep import tccc_pkg::*; #(
   parameter int ROW_LEN = 64,
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int LW = $clog2(DEPTH + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  clr_req_type req,
   input  logic [AW-1:0] row_base,
   output logic        busy,
   output logic        we,
   output logic [AW-1:0] waddr
);

   logic          busy_ff, busy_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [LW-1:0] left_ff, left_in;

   // walk the cell RAM one entry per cycle, clearing the valid bit
   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      left_in = left_ff;
      if (busy_ff) begin
         addr_in = addr_ff + 1'b1;
         left_in = left_ff - 1'b1;
         busy_in = (left_ff != LW'(1));
      end else if (req.all) begin
         busy_in = 1'b1;
         addr_in = '0;
         left_in = LW'(DEPTH);
      end else if (req.row) begin
         busy_in = 1'b1;
         addr_in = row_base;
         left_in = LW'(ROW_LEN);
      end
   end

   // reset starts a full pass
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
         left_ff <= LW'(DEPTH);
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
         left_ff <= left_in;
      end
   end

   assign busy  = busy_ff;
   assign we    = busy_ff;
   assign waddr = addr_ff;

endmodule

### rtl/tccc_core.sv
module tccc_core import tccc_pkg::*; #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 64,
   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int RCW = $clog2(MAX_ROWS + 1),
   localparam int CCW = $clog2(MAX_COLS + 1),
   localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  exec,
   input  logic [7:0]            char_code,
   output logic                  norm_busy,
   output logic                  op_last,
   output rsp_type               rsp_o,
   output clr_req_type           clr_req,
   output logic [AW-1:0]         clr_base,
   output logic                  mem_we,
   output logic [AW-1:0]         mem_waddr,
   output cell_type              mem_wdata,
   output logic [AW-1:0]         mem_raddr
);

   logic [5:0]     num_rows_ff;
   logic [6:0]     num_cols_ff;
   logic [RCW-1:0] rr;
   logic [CCW-1:0] cc;

   logic [CW-1:0] col_ff, col_in, col_st, col_norm;
   logic [RW-1:0] row_ff, row_in, row_st, row_norm;
   logic [RW-1:0] top_ff, top_in, top_st, top_norm;
   logic [RW-1:0] scr_ff, scr_in, scr_st, scr_norm;
   phase_type     phase_ff, phase_in;

   logic [CW:0] col_inc;
   logic [RW:0] row_inc, top_inc, scr_inc;

   logic       op_print, op_nl, wrap, scroll, home, last;
   logic [7:0] op_ch;
   action_type act;

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                               input logic [CW-1:0] col,
                                               input logic [RW-1:0] top,
                                               input logic [RCW-1:0] rows);
      logic [RW:0]   sum;
      logic [RW-1:0] ring;
      sum = {1'b0, row} + {1'b0, top};
      if (sum >= rows) begin
         sum = sum - (RW+1)'(rows);
      end
      ring = sum[RW-1:0];
      return AW'(int'(ring) * MAX_COLS + int'(col));
   endfunction

   // geometry in use, out-of-range values clamped
   always_comb begin
      if (num_rows_ff == '0) begin
         rr = RCW'(1);
      end else if (num_rows_ff > MAX_ROWS) begin
         rr = RCW'(MAX_ROWS);
      end else begin
         rr = RCW'(num_rows_ff);
      end
      if (num_cols_ff == '0) begin
         cc = CCW'(1);
      end else if (num_cols_ff > MAX_COLS) begin
         cc = CCW'(MAX_COLS);
      end else begin
         cc = CCW'(num_cols_ff);
      end
   end

   // after a geometry write: clamp cursor, reduce ring and view by one subtract a cycle
   always_comb begin
      col_norm = (col_ff >= cc) ? CW'(cc - 1'b1) : col_ff;
      row_norm = (row_ff >= rr) ? RW'(rr - 1'b1) : row_ff;
      top_norm = (top_ff >= rr) ? RW'(top_ff - rr) : top_ff;
      scr_norm = (scr_ff >= rr) ? RW'(scr_ff - rr) : scr_ff;
   end

   assign norm_busy = (col_ff >= cc) || (row_ff >= rr) || (top_ff >= rr) || (scr_ff >= rr);

   assign col_inc = {1'b0, col_ff} + 1'b1;
   assign row_inc = {1'b0, row_ff} + 1'b1;
   assign top_inc = {1'b0, top_ff} + 1'b1;
   assign scr_inc = {1'b0, scr_ff} + 1'b1;

   // decode the beat and move the cursor
   always_comb begin
      op_print = 1'b0;
      op_nl    = 1'b0;
      op_ch    = '0;
      act      = ACT_NONE;
      last     = 1'b1;
      home     = 1'b0;
      scroll   = 1'b0;
      col_st   = col_ff;
      row_st   = row_ff;
      top_st   = top_ff;
      scr_st   = scr_ff;
      if (phase_ff == PH_ESC && char_code == CH_LBR) begin
         act = ACT_NONE;
      end else if (phase_ff == PH_CSI && char_code == CH_C) begin
         act = ACT_RIGHT;
         if (col_inc < cc) begin
            col_st = CW'(col_inc);
         end
      end else if (phase_ff == PH_CSI) begin
         // broken sequence: print the held bracket, then the byte as the following op
         op_print = 1'b1;
         op_ch    = CH_LBR;
         last     = 1'b0;
      end else begin
         case (char_code) inside
            CH_NL: begin
               op_nl = 1'b1;
               act   = ACT_NEWLINE;
            end
            CH_BS: begin
               if (col_ff != '0) begin
                  col_st = col_ff - 1'b1;
                  act    = ACT_BACKSPACE;
               end else if (row_ff != '0) begin
                  row_st = row_ff - 1'b1;
                  act    = ACT_BACKSPACE;
               end else begin
                  act = ACT_ERROR;
               end
            end
            CH_CR: begin
               col_st = '0;
               act    = ACT_RETURN;
            end
            CH_FF: begin
               col_st = '0;
               row_st = '0;
               home   = 1'b1;
               act    = ACT_FORMFEED;
            end
            CH_ESC, CH_BEL, CH_NUL: begin
               act = ACT_NONE;
            end
            default: begin
               op_print = 1'b1;
               op_ch    = char_code;
            end
         endcase
      end

      if (op_print) begin
         act = ACT_PRINTED;
      end

      // advance, wrap to the next line, scroll at the bottom
      wrap = op_nl || (op_print && (col_inc >= cc));
      if (op_print && !wrap) begin
         col_st = CW'(col_inc);
      end
      if (wrap) begin
         col_st = '0;
         if (row_inc >= rr) begin
            scroll = 1'b1;
            top_st = (top_inc >= rr) ? '0 : RW'(top_inc);
            scr_st = (scr_inc >= rr) ? '0 : RW'(scr_inc);
         end else begin
            row_st = RW'(row_inc);
         end
      end
   end

   // escape phase next state
   always_comb begin
      phase_in = phase_ff;
      if (exec) begin
         unique case (phase_ff)
            PH_IDLE: phase_in = (char_code == CH_ESC) ? PH_ESC : PH_IDLE;
            PH_ESC: begin
               if (char_code == CH_LBR) begin
                  phase_in = PH_CSI;
               end else if (char_code == CH_ESC) begin
                  phase_in = PH_ESC;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_CSI:  phase_in = PH_IDLE;
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // state next value
   always_comb begin
      if (exec) begin
         col_in = col_st;
         row_in = row_st;
         top_in = top_st;
         scr_in = scr_st;
      end else begin
         col_in = col_norm;
         row_in = row_norm;
         top_in = top_norm;
         scr_in = scr_norm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= 6'd32;
         num_cols_ff <= 7'd64;
         col_ff      <= '0;
         row_ff      <= '0;
         top_ff      <= '0;
         scr_ff      <= '0;
         phase_ff    <= PH_IDLE;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               REG_NUM_ROWS: num_rows_ff <= csr_wdata[5:0];
               REG_NUM_COLS: num_cols_ff <= csr_wdata[6:0];
               default: ;
            endcase
         end
         col_ff   <= col_in;
         row_ff   <= row_in;
         top_ff   <= top_in;
         scr_ff   <= scr_in;
         phase_ff <= phase_in;
      end
   end

   // result fields, cell char is filled in after the RAM read
   always_comb begin
      rsp_o.action            = act;
      rsp_o.printed_char      = op_ch;
      rsp_o.printed_col       = op_print ? 6'(col_ff) : '0;
      rsp_o.printed_row       = op_print ? 5'(row_ff) : '0;
      rsp_o.scrolled          = scroll;
      rsp_o.new_cursor_col    = 6'(col_st);
      rsp_o.new_cursor_row    = 5'(row_st);
      rsp_o.char_under_cursor = '0;
      rsp_o.ring_first_row    = 5'(top_st);
      rsp_o.view_row_offset   = 5'(scr_st);
      rsp_o.last_of_run       = last;
   end

   assign op_last = last;

   // cell RAM accesses and clear requests
   assign mem_we          = exec && op_print;
   assign mem_waddr       = cell_addr(row_ff, col_ff, top_ff, rr);
   assign mem_wdata.valid = 1'b1;
   assign mem_wdata.ch    = op_ch;
   assign mem_raddr       = cell_addr(row_st, col_st, top_st, rr);
   assign clr_req.row     = exec && scroll;
   assign clr_req.all     = exec && home;
   assign clr_base        = AW'(int'(top_ff) * MAX_COLS);

endmodule

### rtl/text_console_cursor_controller.sv
// A result beat passes the input register, stage 1 (RAM read in flight) and the output register;
// when a held '[' is printed first, that beat comes before the byte's own beat.
// Throughput: one result beat per cycle while no clear, offset reduction or back-pressure holds it.
// A scroll clears its row and a formfeed the whole cell RAM, input held meanwhile; after a
// geometry write the input is also held while the offsets are re-reduced.
// Reset (synchronous, active high) zeroes cursor/offsets and runs a clear of the whole cell RAM.
`include "text_console_cursor_controller_assert.svh"

module text_console_cursor_controller import tccc_pkg::*; #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] char_code
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] printed_char, [13:8] printed_col, [18:14] printed_row, [19] scrolled,
   // [25:20] new_cursor_col, [30:26] new_cursor_row, [38:31] char_under_cursor,
   // [43:39] ring_first_row, [48:44] view_row_offset, [55:49] zero
   output logic [55:0]           rsp_tdata,
   output logic [2:0]            rsp_tuser,   // [2:0] action
   output logic                  rsp_tlast,   // last_of_run
   // configuration
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   rsp_type    s1_ff, out_ff, out_in;
   logic       s1_valid_ff, out_valid_ff, s1_move, exec;

   logic          norm_busy, op_last, sweep_busy, sweep_we;
   rsp_type       core_rsp;
   clr_req_type   clr_req;
   logic [AW-1:0] clr_base, sweep_addr;
   logic          core_we;
   logic [AW-1:0] core_waddr, core_raddr;
   cell_type      core_wdata;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;
   cell_type          rd_cell;

   // handshake: an op runs when the cell store is free, no offset reduction is pending and stage 1 can move on
   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign exec       = in_valid_ff && !sweep_busy && !norm_busy && (!s1_valid_ff || s1_move);
   assign req_tready = !in_valid_ff || (exec && op_last);

   tccc_core #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .exec      (exec),
      .char_code (in_char_ff),
      .norm_busy (norm_busy),
      .op_last   (op_last),
      .rsp_o     (core_rsp),
      .clr_req   (clr_req),
      .clr_base  (clr_base),
      .mem_we    (core_we),
      .mem_waddr (core_waddr),
      .mem_wdata (core_wdata),
      .mem_raddr (core_raddr)
   );

   tccc_sweep #(
      .ROW_LEN (MAX_COLS),
      .DEPTH   (DEPTH)
   ) u_sweep (
      .clock    (clock),
      .reset    (reset),
      .req      (clr_req),
      .row_base (clr_base),
      .busy     (sweep_busy),
      .we       (sweep_we),
      .waddr    (sweep_addr)
   );

   // write port shared between printing and clearing
   assign ram_we    = sweep_we || core_we;
   assign ram_waddr = sweep_we ? sweep_addr : core_waddr;
   assign ram_wdata = sweep_we ? '0 : core_wdata;

   tccc_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (exec),
      .raddr (core_raddr),
      .rdata (ram_rdata)
   );

   assign rd_cell = cell_type'(ram_rdata);

   // cell under the cursor: empty after a scroll or formfeed, or when the cell is not valid
   always_comb begin
      out_in = s1_ff;
      if (s1_ff.scrolled || s1_ff.action == ACT_FORMFEED || !rd_cell.valid) begin
         out_in.char_under_cursor = '0;
      end else begin
         out_in.char_under_cursor = rd_cell.ch;
      end
   end

   // input register, stage 1 (RAM read in flight), output register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (exec && op_last) begin
            in_valid_ff <= 1'b0;
         end
         if (exec) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
      end
      if (exec) begin
         s1_ff <= core_rsp;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.action;
   assign rsp_tlast  = out_ff.last_of_run;
   assign rsp_tdata  = {7'b0, out_ff.view_row_offset, out_ff.ring_first_row,
                        out_ff.char_under_cursor, out_ff.new_cursor_row,
                        out_ff.new_cursor_col, out_ff.scrolled, out_ff.printed_row,
                        out_ff.printed_col, out_ff.printed_char};

   // a scroll must start the row clear before the next op
   `TCCC_ASSERT_NEXT(a_scroll_starts_clear, exec && core_rsp.scrolled, sweep_busy, "scroll without row clear")
   // only the held bracket print leaves a run open
   `TCCC_ASSERT_SAME(a_open_run_is_print, out_valid_ff && !out_ff.last_of_run, out_ff.action == ACT_PRINTED, "non-final beat is not a print")
   // a freshly cleared cursor cell reads as empty
   `TCCC_ASSERT_SAME(a_cleared_cell_empty, out_valid_ff && (out_ff.scrolled || out_ff.action == ACT_FORMFEED), out_ff.char_under_cursor == 8'h00, "cleared cell not empty")

endmodule
